>>> sv/cfod_pkg.sv
// Shared types, constants and the sine table generator for the frequency offset derotator.
package cfod_pkg;

	// Phase accumulator width: 2^32 units per full turn
	localparam int unsigned PHASE_BITS = 32;

	// Configuration port widths
	localparam int unsigned CFG_DATA_BITS = 32;
	localparam int unsigned CFG_ADDR_BITS = 3;

	// pi/2 in Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Number of Taylor terms after x in the sine series
	localparam int unsigned SIN_TERMS = 10;

	// Register word index on the configuration port
	typedef enum logic [CFG_ADDR_BITS-3:0] {
		REG_FREQ_WORD = 1'b0
	} cfg_reg_t;

	// Quadrant taken from the top two phase bits
	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// One quarter-wave sine entry, sin(pi/2 * k / 2^addr_bits) scaled to
	// 2^(sample_bits-1), rounded half up and clamped just below one.
	// Evaluated at elaboration only.
	function automatic logic [63:0] sin_entry(input int unsigned k,
			input int unsigned sample_bits, input int unsigned addr_bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] v;
		logic [63:0] smax;
		int unsigned sh;
		sh = 31 - sample_bits;
		x = (HALF_PI_Q30 * 64'(k) + (64'd1 << (addr_bits - 1))) >> addr_bits;
		x2 = (x * x) >> 30;
		term = x;
		acc = x;
		// alternate the sign of each truncated term
		for (int unsigned n = 1; n <= SIN_TERMS; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n[0]) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		v = (acc + (64'd1 << (sh - 1))) >> sh;
		smax = (64'd1 << (sample_bits - 1)) - 64'd1;
		if (v > smax) begin
			v = smax;
		end
		return v;
	endfunction

endpackage

>>> sv/cfod_sin_rom.sv
// Quarter-wave sine table with two registered read ports (sin at idx and at quarter minus idx).
module cfod_sin_rom #(
	parameter int SAMPLE_BITS = 16,
	parameter int TABLE_ADDR_BITS = 10
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [TABLE_ADDR_BITS-1:0] idx,
	output logic [SAMPLE_BITS-1:0]     sin_a_s2,
	output logic [SAMPLE_BITS-1:0]     sin_b_s2
);
	import cfod_pkg::*;

	localparam int DEPTH = (1 << TABLE_ADDR_BITS) + 1;
	localparam logic [TABLE_ADDR_BITS:0] QUARTER = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

	typedef logic [SAMPLE_BITS-1:0] tab_t [DEPTH];

	function automatic tab_t build_tab();
		tab_t t;
		for (int k = 0; k < DEPTH; k++) begin
			t[k] = SAMPLE_BITS'(sin_entry(k, SAMPLE_BITS, TABLE_ADDR_BITS));
		end
		return t;
	endfunction

	localparam tab_t SIN_TAB = build_tab();

	logic [TABLE_ADDR_BITS:0] addr_a;
	logic [TABLE_ADDR_BITS:0] addr_b;

	// Mirror the index for the complementary entry
	assign addr_a = {1'b0, idx};
	assign addr_b = QUARTER - addr_a;

	// Read both entries, hold while the stage is blocked
	always_ff @(posedge clk) begin
		if (en) begin
			sin_a_s2 <= SIN_TAB[addr_a];
			sin_b_s2 <= SIN_TAB[addr_b];
		end
	end

endmodule

>>> sv/carrier_frequency_offset_derotator.sv
// Top level: NCO phase accumulator, sine lookup and complex derotating multiplier.
//
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------
//  in      | in_valid / in_stall     | sample_i, sample_q, first
//  out     | out_valid / out_stall   | out_i, out_q
//  cfg     | psel penable pwrite     | paddr, pwdata, prdata (freq_word)
//
// One transaction in and one out per cycle while out_stall is low; out_valid
// rises once a transaction has passed four register stages in turn: input,
// registered table read, registered multipliers and the result register.
// The phase accumulator add is the only feedback.
// Reset clears the valid bits, freq_word and the phase accumulator.
// out_stall holds the result register; empty earlier stages still fill, and
// in_stall rises only when all four stages hold a transaction.
module carrier_frequency_offset_derotator #(
	parameter int SAMPLE_BITS = 16,
	parameter int TABLE_ADDR_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       sample_i,
	input  logic signed [SAMPLE_BITS-1:0]       sample_q,
	input  logic                                first,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]       out_i,
	output logic signed [SAMPLE_BITS-1:0]       out_q,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cfod_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  logic [cfod_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic [cfod_pkg::CFG_DATA_BITS-1:0]  prdata,
	output logic                                pready
);
	import cfod_pkg::*;

	localparam int W = SAMPLE_BITS;
	localparam logic signed [W+2:0] SAT_MAX = {4'b0000, {(W-1){1'b1}}};
	localparam logic signed [W+2:0] SAT_MIN = {4'b1111, {(W-1){1'b0}}};
	localparam logic signed [2*W+1:0] RND_HALF = (2*W+2)'(1) << (W-2);

	// configuration
	logic                  cfg_wr;
	cfg_reg_t              cfg_idx;
	logic [PHASE_BITS-1:0] freq_word_q;

	// phase accumulator
	logic                  in_acc;
	logic [PHASE_BITS-1:0] phase_cur;
	logic [PHASE_BITS-1:0] phase_acc_q;

	// pipeline control
	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3, ready_s4;

	// stage 1: input register
	logic signed [W-1:0]        si_s1, sq_s1;
	quad_t                      quad_s1;
	logic [TABLE_ADDR_BITS-1:0] idx_s1;

	// stage 2: table read
	logic signed [W-1:0] si_s2, sq_s2;
	quad_t               quad_s2;
	logic [W-1:0]        sin_a_s2, sin_b_s2;
	logic signed [W-1:0] tab_a, tab_b;
	logic signed [W-1:0] cos_v, sin_v;

	// stage 3: products
	logic signed [2*W-1:0] p_ic_s3, p_qs_s3, p_qc_s3, p_is_s3;

	// stage 4: result register
	logic signed [2*W:0]   sum_i, sum_q;
	logic signed [W-1:0]   out_i_s4, out_q_s4;

	// Round half up, shift back to sample scale and clamp
	function automatic logic signed [W-1:0] round_sat(input logic signed [2*W:0] acc);
		logic signed [2*W+1:0] biased;
		logic signed [W+2:0]   shifted;
		biased = (2*W+2)'(acc) + RND_HALF;
		shifted = $signed(biased[2*W+1:W-1]);
		if (shifted > SAT_MAX) begin
			return {1'b0, {(W-1){1'b1}}};
		end else if (shifted < SAT_MIN) begin
			return {1'b1, {(W-1){1'b0}}};
		end
		return shifted[W-1:0];
	endfunction

	// Configuration register access
	assign pready = 1'b1;
	assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_BITS-1:2]);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (cfg_idx == REG_FREQ_WORD) ? freq_word_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_word_q <= '0;
		end else if (cfg_wr && (cfg_idx == REG_FREQ_WORD)) begin
			freq_word_q <= pwdata;
		end
	end

	// Ready chain: a stage takes a transaction when empty or when it moves on
	assign ready_s4 = !out_valid || !out_stall;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;
	assign in_acc = in_valid && !in_stall;

	// Restart phase on the first sample, advance by freq_word per transaction
	assign phase_cur = first ? '0 : phase_acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
		end else if (in_acc) begin
			phase_acc_q <= phase_cur + freq_word_q;
		end
	end

	// Valid bits of all stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				out_valid <= valid_s3;
			end
		end
	end

	// Stage 1: capture sample, quadrant and table index
	always_ff @(posedge clk) begin
		if (ready_s1) begin
			si_s1 <= sample_i;
			sq_s1 <= sample_q;
			quad_s1 <= quad_t'(phase_cur[PHASE_BITS-1 -: 2]);
			idx_s1 <= phase_cur[PHASE_BITS-3 -: TABLE_ADDR_BITS];
		end
	end

	// Stage 2: table lookup
	cfod_sin_rom #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.TABLE_ADDR_BITS(TABLE_ADDR_BITS)
	) u_sin_rom (
		.clk(clk),
		.en(ready_s2),
		.idx(idx_s1),
		.sin_a_s2(sin_a_s2),
		.sin_b_s2(sin_b_s2)
	);

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			si_s2 <= si_s1;
			sq_s2 <= sq_s1;
			quad_s2 <= quad_s1;
		end
	end

	// Fold the quarter-wave entries into cosine and sine by quadrant
	assign tab_a = $signed(sin_a_s2);
	assign tab_b = $signed(sin_b_s2);

	always_comb begin
		case (quad_s2)
			QUAD_0: begin
				sin_v = tab_a;
				cos_v = tab_b;
			end
			QUAD_1: begin
				sin_v = tab_b;
				cos_v = -tab_a;
			end
			QUAD_2: begin
				sin_v = -tab_a;
				cos_v = -tab_b;
			end
			QUAD_3: begin
				sin_v = -tab_b;
				cos_v = tab_a;
			end
			default: begin
				sin_v = tab_a;
				cos_v = tab_b;
			end
		endcase
	end

	// Stage 3: the four partial products
	always_ff @(posedge clk) begin
		if (ready_s3) begin
			p_ic_s3 <= si_s2 * cos_v;
			p_qs_s3 <= sq_s2 * sin_v;
			p_qc_s3 <= sq_s2 * cos_v;
			p_is_s3 <= si_s2 * sin_v;
		end
	end

	// Stage 4: combine, round and saturate into the result register
	assign sum_i = (2*W+1)'(p_ic_s3) + (2*W+1)'(p_qs_s3);
	assign sum_q = (2*W+1)'(p_qc_s3) - (2*W+1)'(p_is_s3);

	always_ff @(posedge clk) begin
		if (ready_s4) begin
			out_i_s4 <= round_sat(sum_i);
			out_q_s4 <= round_sat(sum_q);
		end
	end

	assign out_i = out_i_s4;
	assign out_q = out_q_s4;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && out_valid && out_stall))
		else $error("input stalled while the pipeline has room");

	a_phase_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && first) |=> (phase_acc_q == $past(freq_word_q)))
		else $error("phase did not restart on first sample");

	a_phase_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !first) |=> (phase_acc_q == $past(phase_acc_q + freq_word_q)))
		else $error("phase did not advance by freq_word");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(phase_acc_q))
		else $error("phase moved without a transaction");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !valid_s3) |=> !out_valid)
		else $error("result repeated after being taken");
`endif

endmodule
